### rtl/core/nppl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nppl_pkg
// Types and constants shared by the nearest path point lookahead block.
// ----------------------------------------------------------------------------
package nppl_pkg;

    localparam int COORD_W = 24;
    localparam int STEP_W  = 10;
    localparam int OIDX_W  = 10;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = 54;

    // (1e5 m)^2 in mm^2
    localparam logic [DIST_W-1:0] FAR_SQ_MM2 = 54'd10_000_000_000_000_000;

    localparam logic [STEP_W-1:0] LOOKAHEAD_RESET = 10'd50;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_GOAL_RD,
        ST_GOAL_OUT
    } nppl_state_t;

    typedef struct packed {
        logic                      opcode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      last_point;
    } nppl_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
        logic [OIDX_W-1:0]         goal_index;
        logic [OIDX_W-1:0]         nearest_index;
    } nppl_rsp_t;

endpackage

### rtl/core/nppl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nppl_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nppl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/nearest_path_point_lookahead_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_path_point_lookahead_top
// Stores one 2-D path and answers pose requests with a lookahead goal point.
// ----------------------------------------------------------------------------
// A load request writes one point into the path RAM; the request with
// last_point set closes the path, and later loads are dropped. A pose
// request scans the whole stored path through the single RAM read port, one
// point per cycle, and holds the block busy until its answer is loaded into
// the output register; a pose that comes before the path is closed is
// dropped. Ties go to the lower index. The answer sits in an output
// register, and the block takes the next request while it waits. The path
// RAM needs no clearing after reset.
module nearest_path_point_lookahead_top #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nppl_pkg::nppl_req_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output nppl_pkg::nppl_rsp_t out_data,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data
);

    import nppl_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int LEN_W  = $clog2(MAX_POINTS + 1);
    localparam int GSUM_W = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;
    localparam int MEM_W  = 2 * COORD_W;

    nppl_state_t state_reg, state_next;

    logic [STEP_W-1:0]  lookahead_reg;
    logic [LEN_W-1:0]   path_len_reg;
    logic               path_complete_reg;
    logic [IDX_W-1:0]   last_nearest_reg;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic [IDX_W-1:0]   goal_idx_reg;
    logic [DIST_W-1:0]  best_reg;

    logic signed [COORD_W-1:0] pose_x_reg, pose_y_reg;

    logic               p1_v_reg, p2_v_reg, p3_v_reg;
    logic [IDX_W-1:0]   p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [DIFF_W-1:0]  p2_dx_reg, p2_dy_reg;
    logic [SQ_W-1:0]    p3_sqx_reg, p3_sqy_reg;

    logic               out_valid_reg;
    nppl_rsp_t          out_data_reg;

    logic               accept;
    logic               load_wr;
    logic               pose_go;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [MEM_W-1:0]   rd_data;
    logic               out_load;
    logic [LEN_W-1:0]   last_idx;
    logic [GSUM_W-1:0]  goal_sum;
    logic [IDX_W-1:0]   goal_idx;
    logic               pipe_busy;

    logic signed [COORD_W-1:0] mem_x, mem_y;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [SQ_W-1:0]           sqx, sqy;
    logic [DIST_W-1:0]         sq_dist;
    logic [GSUM_W-1:0]         goal_ext, nearest_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_wr   = accept && (in_data.opcode == OP_LOAD) && !path_complete_reg
                       && (path_len_reg < LEN_W'(MAX_POINTS));
    assign pose_go   = accept && (in_data.opcode == OP_POSE) && path_complete_reg;
    assign last_idx  = path_len_reg - LEN_W'(1);
    assign pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg;

    assign goal_sum = GSUM_W'(last_nearest_reg) + GSUM_W'(lookahead_reg);
    assign goal_idx = (goal_sum > GSUM_W'(last_idx)) ? last_idx[IDX_W-1:0]
                                                      : goal_sum[IDX_W-1:0];

    nppl_ram #(
        .WIDTH(MEM_W),
        .DEPTH(MAX_POINTS)
    ) u_path_ram (
        .clk    (clk),
        .wr_en  (load_wr),
        .wr_addr(path_len_reg[IDX_W-1:0]),
        .wr_data({in_data.pos_x, in_data.pos_y}),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = scan_addr_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pose_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
                if (scan_addr_reg == last_idx[IDX_W-1:0])
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_GOAL_RD;
                end
            end
            ST_GOAL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = goal_idx;
                state_next = ST_GOAL_OUT;
            end
            ST_GOAL_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg     <= LOOKAHEAD_RESET;
            path_len_reg      <= '0;
            path_complete_reg <= 1'b0;
            last_nearest_reg  <= '0;
            scan_addr_reg     <= '0;
            p1_v_reg          <= 1'b0;
            p2_v_reg          <= 1'b0;
            p3_v_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lookahead_reg <= cfg_wr_data;
            end
            if (load_wr)
            begin
                path_len_reg <= path_len_reg + LEN_W'(1);
            end
            if (accept && (in_data.opcode == OP_LOAD) && in_data.last_point)
            begin
                path_complete_reg <= 1'b1;
            end
            if (pose_go)
            begin
                scan_addr_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
            end
            p1_v_reg <= (state_reg == ST_SCAN);
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (p3_v_reg && (sq_dist < best_reg))
            begin
                last_nearest_reg <= p3_idx_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath
    assign mem_x   = rd_data[MEM_W-1:COORD_W];
    assign mem_y   = rd_data[COORD_W-1:0];
    assign dx      = {mem_x[COORD_W-1], mem_x} - {pose_x_reg[COORD_W-1], pose_x_reg};
    assign dy      = {mem_y[COORD_W-1], mem_y} - {pose_y_reg[COORD_W-1], pose_y_reg};
    assign sqx     = p2_dx_reg * p2_dx_reg;
    assign sqy     = p2_dy_reg * p2_dy_reg;
    assign sq_dist = DIST_W'(p3_sqx_reg) + DIST_W'(p3_sqy_reg);

    assign goal_ext    = GSUM_W'(goal_idx_reg);
    assign nearest_ext = GSUM_W'(last_nearest_reg);

    always_ff @(posedge clk)
    begin
        if (pose_go)
        begin
            pose_x_reg <= in_data.pos_x;
            pose_y_reg <= in_data.pos_y;
            best_reg   <= FAR_SQ_MM2;
        end
        else if (p3_v_reg && (sq_dist < best_reg))
        begin
            best_reg <= sq_dist;
        end
        p1_idx_reg <= scan_addr_reg;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        p2_dx_reg  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        p2_dy_reg  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        p3_sqx_reg <= sqx;
        p3_sqy_reg <= sqy;
        if (state_reg == ST_GOAL_RD)
        begin
            goal_idx_reg <= goal_idx;
        end
        if (out_load)
        begin
            out_data_reg.goal_x        <= mem_x;
            out_data_reg.goal_y        <= mem_y;
            out_data_reg.goal_index    <= goal_ext[OIDX_W-1:0];
            out_data_reg.nearest_index <= nearest_ext[OIDX_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_from_goal: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_GOAL_OUT))
        else $error("result raised outside goal stage");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("scan pipeline busy while taking requests");

    a_scan_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (LEN_W'(scan_addr_reg) < path_len_reg))
        else $error("scan address beyond stored path");

    a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        path_complete_reg |=> path_complete_reg)
        else $error("path complete flag cleared");

endmodule
